### sv/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg: shared constants, types and tables of the sound generator
// Command codes, register masks, level table and the tick engine status struct.
// ----------------------------------------------------------------------------
`default_nettype none
package psg_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_RENDER = 2'd2;

  localparam logic [1:0] ENV_HOLD = 2'd0;
  localparam logic [1:0] ENV_UP   = 2'd1;
  localparam logic [1:0] ENV_DOWN = 2'd2;

  localparam int unsigned TICK_W = 12;
  localparam int unsigned GAIN_W = 10;
  localparam int unsigned LEVEL_W = 18;
  localparam int unsigned SUM_W = 26;
  localparam logic [15:0] MASK4_SET = 16'h202a;
  localparam logic [15:0] MASK5_SET = 16'h0740;
  // Reciprocal of 300 scaled by 2^35 and rounded up; exact for sums below 2^26.
  localparam int unsigned RECIP_W = 27;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] LEVEL_RECIP = 27'd114532462;

  localparam logic [2:0] CFG_YM      = 3'd0;
  localparam logic [2:0] CFG_PRESCALE = 3'd1;

  typedef struct packed {
    logic [2:0]  tone_bits;
    logic        noise_bit;
    logic [5:0]  env_level;
  } psg_gen_status_t;

  function automatic logic [14:0] level_lookup(input logic [5:0] idx);
    logic [14:0] v;
    case (idx[4:1])
      4'd0:  v = 15'd0;
      4'd1:  v = 15'd463;
      4'd2:  v = 15'd980;
      4'd3:  v = 15'd1555;
      4'd4:  v = 15'd2195;
      4'd5:  v = 15'd2908;
      4'd6:  v = 15'd3701;
      4'd7:  v = 15'd4584;
      4'd8:  v = 15'd5567;
      4'd9:  v = 15'd6662;
      4'd10: v = 15'd7880;
      4'd11: v = 15'd9237;
      4'd12: v = 15'd10747;
      4'd13: v = 15'd12428;
      4'd14: v = 15'd14300;
      default: v = 15'd16384;
    endcase
    if (idx[5]) begin
      // Linear table: step 528, entry one is zero.
      v = (idx[4:0] == 5'd1) ? 15'd0 : 15'(idx[4:0]) * 15'd528;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/psg_gen.sv
// ----------------------------------------------------------------------------
// psg_gen: tone, noise and envelope generators
// Advances all generators by one prescaled tick when step is high and no envelope restart is asked.
// ----------------------------------------------------------------------------
`default_nettype none
module psg_gen (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [15:0] period_a,
  input  wire logic [15:0] period_b,
  input  wire logic [15:0] period_c,
  input  wire logic [4:0]  noise_period,
  input  wire logic [15:0] env_period,
  input  wire logic [3:0]  env_shape,
  input  wire logic        env_restart,
  input  wire logic        env_restart_up,
  output psg_pkg::psg_gen_status_t status
);

  logic [15:0] tone_cnt_r [3];
  logic [2:0]  tone_bit_r;
  logic [7:0]  noise_cnt_r;
  logic [16:0] noise_shift_r;
  logic        noise_bit_r;
  logic [15:0] env_cnt_r;
  logic [5:0]  env_lvl_r;
  logic [1:0]  env_dir_r;

  logic [15:0] periods [3];
  logic [16:0] tone_inc [3];
  logic [8:0]  noise_inc;
  logic [16:0] env_inc;
  logic [6:0]  lvl_s;
  logic [5:0]  lvl_nxt;
  logic [1:0]  dir_nxt;
  logic        out_range;

  assign periods[0] = period_a;
  assign periods[1] = period_b;
  assign periods[2] = period_c;

  always_comb begin
    for (int i = 0; i < 3; i++) tone_inc[i] = {1'b0, tone_cnt_r[i]} + 17'd1;
    noise_inc = {1'b0, noise_cnt_r} + 9'd1;
    env_inc = {1'b0, env_cnt_r} + 17'd1;
    lvl_s = {1'b0, env_lvl_r};
    if (env_dir_r == psg_pkg::ENV_UP) lvl_s = lvl_s + 7'd1;
    else if (env_dir_r == psg_pkg::ENV_DOWN) lvl_s = lvl_s - 7'd1;
    out_range = lvl_s[6] || (lvl_s > 7'd31);
    lvl_nxt = lvl_s[5:0];
    dir_nxt = env_dir_r;
    if (out_range) begin
      case (env_shape)
        4'd8, 4'd12: lvl_nxt = lvl_s[6] ? 6'd31 : 6'd0;
        4'd10, 4'd14: begin
          if (env_dir_r == psg_pkg::ENV_UP) begin
            dir_nxt = psg_pkg::ENV_DOWN;
            lvl_nxt = 6'(lvl_s - 7'd1);
          end else begin
            dir_nxt = psg_pkg::ENV_UP;
            lvl_nxt = 6'(lvl_s + 7'd1);
          end
        end
        4'd11, 4'd13: begin
          lvl_nxt = 6'd31;
          dir_nxt = psg_pkg::ENV_HOLD;
        end
        default: begin
          lvl_nxt = 6'd0;
          dir_nxt = psg_pkg::ENV_HOLD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) tone_cnt_r[i] <= '0;
      tone_bit_r <= '0;
      noise_cnt_r <= '0;
      noise_shift_r <= '0;
      noise_bit_r <= 1'b0;
      env_cnt_r <= '0;
      env_lvl_r <= '0;
      env_dir_r <= psg_pkg::ENV_HOLD;
    end else if (env_restart) begin
      env_cnt_r <= '0;
      env_lvl_r <= env_restart_up ? 6'd0 : 6'd31;
      env_dir_r <= env_restart_up ? psg_pkg::ENV_UP : psg_pkg::ENV_DOWN;
    end else if (step) begin
      for (int i = 0; i < 3; i++) begin
        if (tone_inc[i] >= {1'b0, periods[i]}) begin
          tone_cnt_r[i] <= '0;
          tone_bit_r[i] <= ~tone_bit_r[i];
        end else begin
          tone_cnt_r[i] <= tone_inc[i][15:0];
        end
      end
      if (noise_inc >= {3'b0, noise_period, 1'b0}) begin
        noise_cnt_r <= '0;
        noise_shift_r <= {noise_shift_r[15:0], 1'b1} ^
                         {16'd0, noise_shift_r[16] ^ noise_shift_r[13]};
        noise_bit_r <= noise_shift_r[15];
      end else begin
        noise_cnt_r <= noise_inc[7:0];
      end
      if (env_inc >= {1'b0, env_period}) begin
        env_cnt_r <= '0;
        env_lvl_r <= lvl_nxt;
        env_dir_r <= dir_nxt;
      end else begin
        env_cnt_r <= env_inc[15:0];
      end
    end
  end

  assign status.tone_bits = tone_bit_r;
  assign status.noise_bit = noise_bit_r;
  assign status.env_level = env_lvl_r;

`ifndef SYNTHESIS
  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_dir_r != psg_pkg::ENV_HOLD |-> env_lvl_r <= 6'd31 || $past(env_restart))
    else $error("envelope level out of range");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    env_restart |=> env_cnt_r == 16'd0)
    else $error("envelope restart did not clear counter");
  a_noise_width: assert property (@(posedge clk) disable iff (!rst_n)
    !step && !env_restart |=> $stable(noise_shift_r))
    else $error("noise shifted without a tick");
`endif

endmodule
`default_nettype wire

### sv/psg_mac.sv
// ----------------------------------------------------------------------------
// psg_mac: shared multiply-accumulate and divide-by-300 unit
// Six multiply-accumulate steps, then a reciprocal multiplication for the
// divide by 300, left sum first and right sum in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module psg_mac #(
  parameter int unsigned GAIN_W = psg_pkg::GAIN_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [14:0]       lv [3],
  input  wire logic [GAIN_W-1:0] gains [6],
  output logic                   done,
  output logic [psg_pkg::LEVEL_W-1:0] left_q,
  output logic [psg_pkg::LEVEL_W-1:0] right_q
);

  localparam int unsigned SW = psg_pkg::SUM_W;
  localparam int unsigned PW = psg_pkg::SUM_W + psg_pkg::RECIP_W;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]    state_r;
  logic [2:0]    idx_r;
  logic          side_r;
  logic [SW-1:0] acc_r [2];
  logic [psg_pkg::LEVEL_W-1:0] quo_r [2];
  logic [14:0]   mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [SW-1:0] prod;
  logic [PW-1:0] recip_prod;

  assign mul_a = lv[idx_r[2:1]];
  assign mul_b = gains[idx_r];
  assign prod = SW'(mul_a) * SW'(mul_b);

  // The quotient is the top bits of the sum times the scaled reciprocal.
  assign recip_prod = PW'(acc_r[side_r]) * PW'(psg_pkg::LEVEL_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      side_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          state_r <= S_MAC;
          idx_r <= '0;
          acc_r[0] <= '0;
          acc_r[1] <= '0;
        end
        S_MAC: begin
          acc_r[idx_r[0]] <= acc_r[idx_r[0]] + prod;
          if (idx_r == 3'd5) begin
            state_r <= S_DIV;
            side_r <= 1'b0;
          end
          idx_r <= idx_r + 3'd1;
        end
        S_DIV: begin
          quo_r[side_r] <= recip_prod[psg_pkg::RECIP_SHIFT +: psg_pkg::LEVEL_W];
          if (side_r) begin
            state_r <= S_IDLE;
            done <= 1'b1;
          end
          side_r <= ~side_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign left_q = quo_r[0];
  assign right_q = quo_r[1];

`ifndef SYNTHESIS
  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(state_r) == S_DIV)
    else $error("done without divide");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |=> state_r == S_MAC || state_r == S_DIV)
    else $error("accumulate left early");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> idx_r <= 3'd5)
    else $error("index past last gain");
`endif

endmodule
`default_nettype wire

### sv/psg_three_voice_sound_generator.sv
// ----------------------------------------------------------------------------
// psg_three_voice_sound_generator: three-voice sound generator, top level
// Register file, bus decode, tick sequencer and result stage.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as transactions on the in_ stream: a bus write, a
// bus read or a render. A write gives no result; a read or a render gives one
// transaction on the out_ stream. The user must write settings (table variant,
// prescaler, six channel gains) through the cfg_ channel only while the block
// idles; the block itself does not enforce it. A render walks its tick count
// one input tick per cycle with the shared generator unit, then closes the
// tick phase, starts the shared unit, runs one multiply-accumulate step per
// channel gain and two reciprocal multiplications for the divide by 300, and
// loads the output register. The next item can be taken only once the result
// has left the output register. in_tready is low while an item is at work or
// its result is still held. Reset (synchronous, rst_n low) clears generators,
// selection, table variant and prescaler select and sets every channel gain
// to 100; the mixer register comes up as all ones. If the receiver stalls,
// the result waits in the output register and no new item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module psg_three_voice_sound_generator #(
  parameter int unsigned GAIN_W = psg_pkg::GAIN_W,
  parameter int unsigned TICK_W = psg_pkg::TICK_W
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: bus_address[15:0], write_data[23:16], tick_count[TICK_W+23:24], zero pad
  input  wire logic [((TICK_W+24+7)/8)*8-1:0] in_tdata,
  input  wire logic [1:0]  in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: read_data[7:0], left_level[25:8], right_level[43:26], zero pad
  output logic [47:0]      out_tdata,
  output logic             out_tuser,  // read_hit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [GAIN_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_MAC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_r;
  logic [7:0]  regs_r [16];
  logic [7:0]  sel_r;
  logic [3:0]  presc_r;
  logic [TICK_W-1:0] ticks_r;
  logic        ym_r;
  logic        p8_r;
  logic [GAIN_W-1:0] gains_r [6];
  logic        hit_r;
  logic [7:0]  rdata_r;
  logic [psg_pkg::LEVEL_W-1:0] left_r, right_r;
  logic        mac_start_r;

  logic        in_acc;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [7:0]  wmasked;
  logic [TICK_W-1:0] tcount;
  logic        sel_hit;
  logic        env_restart;
  logic        step;
  logic [3:0]  presc_nxt;
  logic [14:0] lv [3];
  logic        mac_done;
  logic [psg_pkg::LEVEL_W-1:0] mac_l, mac_r;
  psg_pkg::psg_gen_status_t gst;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc = in_tvalid && in_tready;
  assign addr = in_tdata[15:0];
  assign wdata = in_tdata[23:16];
  assign tcount = in_tdata[TICK_W+23:24];
  assign sel_hit = (addr & 16'hc0ff) == 16'hc0fd;

  always_comb begin
    wmasked = wdata;
    if (psg_pkg::MASK4_SET[sel_r[3:0]]) wmasked = wdata & 8'h0f;
    if (psg_pkg::MASK5_SET[sel_r[3:0]]) wmasked = wdata & 8'h1f;
  end

  assign env_restart = in_acc && in_tuser == psg_pkg::CMD_WRITE && !addr[1] && !sel_hit &&
                       (addr & 16'hc000) == 16'h8000 && sel_r == 8'd13;

  assign presc_nxt = presc_r + 4'd1;
  assign step = state_r == S_TICK && ticks_r != '0 &&
                (p8_r ? presc_nxt[2:0] == 3'd0 : presc_nxt == 4'd0);

  // Channel level lookups from the generator status.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [4:0] idx;
      idx = regs_r[8+ch][4] ? gst.env_level[4:0] : {regs_r[8+ch][3:0], 1'b1};
      if (!((regs_r[7][ch] || gst.tone_bits[ch]) &&
            (regs_r[7][ch+3] || gst.noise_bit))) idx = 5'd0;
      lv[ch] = psg_pkg::level_lookup({ym_r, idx});
    end
  end

  psg_gen u_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .period_a       ({regs_r[1], regs_r[0]}),
    .period_b       ({regs_r[3], regs_r[2]}),
    .period_c       ({regs_r[5], regs_r[4]}),
    .noise_period   (regs_r[6][4:0]),
    .env_period     ({regs_r[12], regs_r[11]}),
    .env_shape      (regs_r[13][3:0]),
    .env_restart    (env_restart),
    .env_restart_up (wmasked[2]),
    .status         (gst)
  );

  psg_mac #(.GAIN_W(GAIN_W)) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start_r),
    .lv      (lv),
    .gains   (gains_r),
    .done    (mac_done),
    .left_q  (mac_l),
    .right_q (mac_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 16; i++) regs_r[i] <= (i == 7) ? 8'hff : 8'h00;
      sel_r <= '0;
      presc_r <= '0;
      ym_r <= 1'b0;
      p8_r <= 1'b0;
      for (int i = 0; i < 6; i++) gains_r[i] <= GAIN_W'(100);
      mac_start_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      mac_start_r <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == psg_pkg::CFG_YM) ym_r <= cfg_data[0];
        else if (cfg_index == psg_pkg::CFG_PRESCALE) p8_r <= cfg_data[0];
        else gains_r[cfg_index - 3'd2] <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (in_acc) begin
          case (in_tuser)
            psg_pkg::CMD_WRITE: if (!addr[1]) begin
              if (sel_hit) sel_r <= ym_r ? wdata : {4'd0, wdata[3:0]};
              else if ((addr & 16'hc000) == 16'h8000 && sel_r[7:4] == 4'd0)
                regs_r[sel_r[3:0]] <= wmasked;
            end
            psg_pkg::CMD_READ: begin
              hit_r <= sel_hit && sel_r[7:4] == 4'd0;
              rdata_r <= (sel_hit && sel_r[7:4] == 4'd0) ? regs_r[sel_r[3:0]] : 8'd0;
              left_r <= '0;
              right_r <= '0;
              out_tvalid <= 1'b1;
              state_r <= S_OUT;
            end
            psg_pkg::CMD_RENDER: begin
              ticks_r <= tcount;
              state_r <= S_TICK;
            end
            default: ;
          endcase
        end
        S_TICK: begin
          if (ticks_r == '0) begin
            mac_start_r <= 1'b1;
            state_r <= S_MAC;
          end else begin
            presc_r <= presc_nxt;
            ticks_r <= ticks_r - TICK_W'(1);
          end
        end
        S_MAC: if (mac_done) begin
          hit_r <= 1'b0;
          rdata_r <= '0;
          left_r <= mac_l;
          right_r <= mac_r;
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          out_tvalid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {4'd0, right_r, left_r, rdata_r};
  assign out_tuser = hit_r;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_OUT)
    else $error("result shown outside output state");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> state_r == S_TICK)
    else $error("tick outside render");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the three-voice sound generator
// Bus writes, bus reads and renders are streamed into the block while a
// tracking model of the registers, tone, noise and envelope generators
// predicts each read and render transaction, which the monitor compares.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psg_pkg::*;

  // Gain register indexes follow the table variant and prescaler selects.
  localparam logic [2:0] CFG_GAIN_AL = 3'd2;
  localparam logic [2:0] CFG_GAIN_AR = 3'd3;
  localparam logic [2:0] CFG_GAIN_BL = 3'd4;
  localparam logic [2:0] CFG_GAIN_BR = 3'd5;
  localparam logic [2:0] CFG_GAIN_CL = 3'd6;
  localparam logic [2:0] CFG_GAIN_CR = 3'd7;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Bus addresses: register select port, data port, a port with bit 1 set.
  localparam logic [15:0] ADDR_SEL  = 16'hfffd;
  localparam logic [15:0] ADDR_DATA = 16'hbffd;
  localparam logic [15:0] ADDR_OFF  = 16'hbfff;

  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [11:0] ticks;
  } psg_item_t;

  typedef struct {
    logic        hit;
    logic [7:0]  rdata;
    logic [17:0] left;
    logic [17:0] right;
  } psg_sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  psg_three_voice_sound_generator i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Tracking model of the generator: settings, register file and counters.
  int unsigned volume_rom[64] = '{
    0, 0, 463, 463, 980, 980, 1555, 1555,
    2195, 2195, 2908, 2908, 3701, 3701, 4584, 4584,
    5567, 5567, 6662, 6662, 7880, 7880, 9237, 9237,
    10747, 10747, 12428, 12428, 14300, 14300, 16384, 16384,
    0, 0, 1056, 1584, 2112, 2640, 3168, 3696,
    4224, 4752, 5280, 5808, 6336, 6864, 7392, 7920,
    8448, 8976, 9504, 10032, 10560, 11088, 11616, 12144,
    12672, 13200, 13728, 14256, 14784, 15312, 15840, 16368
  };

  logic        m_ym;
  logic        m_by_eight;
  logic [9:0]  m_gain[6];
  logic [7:0]  m_regs[16];
  logic [7:0]  m_sel;
  logic [3:0]  m_presc;
  logic [15:0] m_tone_cnt[3];
  logic        m_tone_bit[3];
  logic [7:0]  m_noise_cnt;
  logic [16:0] m_lfsr;
  logic        m_noise_bit;
  logic [15:0] m_env_cnt;
  logic [5:0]  m_env_lvl;
  logic [1:0]  m_env_dir;

  psg_item_t   pending_items[$];
  psg_sample_t expected_samples[$];
  psg_item_t   cur_item;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;

  task automatic model_reset();
    m_ym = 1'b0;
    m_by_eight = 1'b0;
    foreach (m_gain[i]) m_gain[i] = 10'd100;
    foreach (m_regs[i]) m_regs[i] = 8'h00;
    m_regs[7] = 8'hff;
    m_sel = '0;
    m_presc = '0;
    foreach (m_tone_cnt[i]) begin
      m_tone_cnt[i] = '0;
      m_tone_bit[i] = 1'b0;
    end
    m_noise_cnt = '0;
    m_lfsr = '0;
    m_noise_bit = 1'b0;
    m_env_cnt = '0;
    m_env_lvl = '0;
    m_env_dir = ENV_HOLD;
  endtask

  task automatic envelope_advance();
    int lvl;
    logic [3:0] shape;
    lvl = m_env_lvl;
    shape = m_regs[13][3:0];
    if (m_env_dir == ENV_UP) lvl++;
    else if (m_env_dir == ENV_DOWN) lvl--;
    if (lvl < 0 || lvl > 31) begin
      if (shape == 4'd8 || shape == 4'd12) begin
        lvl = (lvl < 0) ? 31 : 0;
      end else if (shape == 4'd10 || shape == 4'd14) begin
        // Triangle shapes turn round and take one step the other way.
        if (m_env_dir == ENV_UP) begin
          m_env_dir = ENV_DOWN;
          lvl--;
        end else begin
          m_env_dir = ENV_UP;
          lvl++;
        end
      end else if (shape == 4'd11 || shape == 4'd13) begin
        lvl = 31;
        m_env_dir = ENV_HOLD;
      end else begin
        lvl = 0;
        m_env_dir = ENV_HOLD;
      end
    end
    m_env_lvl = 6'(lvl);
  endtask

  task automatic generator_tick();
    int unsigned c;
    int unsigned period;
    logic fb;
    for (int ch = 0; ch < 3; ch++) begin
      period = {m_regs[2*ch+1], m_regs[2*ch]};
      c = m_tone_cnt[ch] + 1;
      if (c >= period) begin
        c = 0;
        m_tone_bit[ch] = ~m_tone_bit[ch];
      end
      m_tone_cnt[ch] = 16'(c);
    end
    c = m_noise_cnt + 1;
    if (c >= m_regs[6] * 2) begin
      fb = m_lfsr[16] ^ m_lfsr[13];
      c = 0;
      m_lfsr = {m_lfsr[15:0], 1'b1} ^ {16'd0, fb};
      m_noise_bit = m_lfsr[16];
    end
    m_noise_cnt = 8'(c);
    period = {m_regs[12], m_regs[11]};
    c = m_env_cnt + 1;
    if (c >= period) begin
      c = 0;
      envelope_advance();
    end
    m_env_cnt = 16'(c);
  endtask

  function automatic int unsigned voice_level(int ch);
    logic [7:0] vol;
    logic [4:0] idx;
    logic tone_on, noise_on;
    vol = m_regs[8+ch];
    idx = vol[4] ? m_env_lvl[4:0] : {vol[3:0], 1'b1};
    tone_on = m_regs[7][ch] | m_tone_bit[ch];
    noise_on = m_regs[7][ch+3] | m_noise_bit;
    if (!(tone_on && noise_on)) idx = '0;
    return volume_rom[(m_ym ? 32 : 0) + idx];
  endfunction

  // Apply one accepted command to the model and queue the sample it causes.
  task automatic predict_command(psg_item_t it);
    psg_sample_t s;
    logic [7:0] d;
    int unsigned lsum, rsum, lv;
    s = '{hit: 1'b0, rdata: 8'h00, left: '0, right: '0};
    case (it.cmd)
      CMD_WRITE: begin
        d = it.wdata;
        if (!it.addr[1]) begin
          if ((it.addr & 16'hc0ff) == 16'hc0fd) begin
            m_sel = m_ym ? d : {4'h0, d[3:0]};
          end else if ((it.addr & 16'hc000) == 16'h8000 && m_sel < 16) begin
            if (MASK4_SET[m_sel[3:0]]) d &= 8'h0f;
            if (MASK5_SET[m_sel[3:0]]) d &= 8'h1f;
            m_regs[m_sel[3:0]] = d;
            if (m_sel == 8'd13) begin
              // A shape write restarts the envelope from one end.
              m_env_cnt = '0;
              if (d[2]) begin
                m_env_lvl = 6'd0;
                m_env_dir = ENV_UP;
              end else begin
                m_env_lvl = 6'd31;
                m_env_dir = ENV_DOWN;
              end
            end
          end
        end
      end
      CMD_READ: begin
        s.hit = ((it.addr & 16'hc0ff) == 16'hc0fd) && m_sel < 16;
        s.rdata = s.hit ? m_regs[m_sel[3:0]] : 8'h00;
        expected_samples.push_back(s);
      end
      CMD_RENDER: begin
        for (int t = 0; t < it.ticks; t++) begin
          m_presc = m_presc + 4'd1;
          if ((m_presc & (m_by_eight ? 4'd7 : 4'd15)) == 4'd0) generator_tick();
        end
        lsum = 0;
        rsum = 0;
        for (int ch = 0; ch < 3; ch++) begin
          lv = voice_level(ch);
          lsum += lv * m_gain[2*ch];
          rsum += lv * m_gain[2*ch+1];
        end
        s.left = 18'(lsum / 300);
        s.right = 18'(rsum / 300);
        expected_samples.push_back(s);
      end
      default: ;
    endcase
  endtask

  // Driver: a new transaction is offered only once the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_command(cur_item);
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'h0, cur_item.ticks, cur_item.wdata, cur_item.addr};
          in_tuser <= cur_item.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transaction is checked against the oldest sample.
  always @(posedge clk) begin
    psg_sample_t e;
    if (rst_n) begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result transaction, tdata %h", out_tdata);
          errors++;
        end else begin
          e = expected_samples.pop_front();
          if (out_tuser !== e.hit) begin
            $error("read_hit: expected %0d, actual %0d", e.hit, out_tuser);
            errors++;
          end
          if (out_tdata[7:0] !== e.rdata) begin
            $error("read_data: expected %0d, actual %0d", e.rdata, out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[25:8] !== e.left) begin
            $error("left_level: expected %0d, actual %0d", e.left, out_tdata[25:8]);
            errors++;
          end
          if (out_tdata[43:26] !== e.right) begin
            $error("right_level: expected %0d, actual %0d", e.right, out_tdata[43:26]);
            errors++;
          end
        end
      end
    end
  end

  task automatic queue_item(logic [1:0] cmd, logic [15:0] addr, logic [7:0] d,
                            logic [11:0] ticks);
    pending_items.push_back('{cmd: cmd, addr: addr, wdata: d, ticks: ticks});
  endtask

  task automatic write_setting(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_YM) m_ym = val[0];
    else if (idx == CFG_PRESCALE) m_by_eight = val[0];
    else m_gain[idx - CFG_GAIN_AL] = val;
  endtask

  // Sender holds off until every queued command is gone and every result has
  // arrived, then lets the block settle after a command that gives no result.
  task automatic wait_until_idle();
    @(negedge clk);
    while (pending_items.size() > 0 || in_tvalid || expected_samples.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly select-then-write pairs, reads and short renders,
  // with a share of arbitrary addresses and the odd long render.
  task automatic queue_random(int count);
    int r;
    logic [7:0] reg_no, d;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        reg_no = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        d = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        queue_item(CMD_WRITE, {2'b11, 6'($urandom), 8'hfd}, reg_no, 12'($urandom));
        queue_item(CMD_WRITE, {2'b10, 12'($urandom), 1'b0, 1'($urandom)}, d,
                   12'($urandom));
      end else if (r < 55) begin
        queue_item(CMD_READ, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                   : {2'b11, 6'($urandom), 8'hfd}, 8'($urandom), 12'($urandom));
      end else if (r < 85) begin
        queue_item(CMD_RENDER, 16'($urandom), 8'($urandom),
                   ($urandom_range(0, 49) == 0) ? 12'($urandom) : 12'($urandom_range(0, 160)));
      end else if (r < 95) begin
        queue_item(CMD_WRITE, 16'($urandom), 8'($urandom), 12'($urandom));
      end else begin
        queue_item(CMD_NONE, 16'($urandom), 8'($urandom), 12'($urandom));
      end
    end
  endtask

  task automatic select_and_write(logic [7:0] reg_no, logic [7:0] d);
    queue_item(CMD_WRITE, ADDR_SEL, reg_no, 12'h000);
    queue_item(CMD_WRITE, ADDR_DATA, d, 12'h000);
  endtask

  initial begin
    logic [9:0] g;
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      // Idling pattern: fast sender with busy receiver, then the reverse,
      // then full speed on both sides.
      case (phase / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_setting(CFG_YM, (phase == 1 || phase == 3) ? 10'd1
                    : (phase == 4) ? 10'($urandom_range(0, 1)) : 10'd0);
      write_setting(CFG_PRESCALE, (phase == 1 || phase == 2) ? 10'd1
                    : (phase == 4) ? 10'($urandom_range(0, 1)) : 10'd0);
      for (int k = 0; k < 6; k++) begin
        case (phase)
          0: g = 10'd100;
          1, 5: g = 10'd1023;
          2: g = 10'd0;
          default: g = 10'($urandom);
        endcase
        write_setting(CFG_GAIN_AL + 3'(k), g);
      end
      if (phase == 0) begin
        // Reads straight after reset, a miss, and the masked registers.
        queue_item(CMD_READ, ADDR_SEL, 8'h00, 12'h000);
        queue_item(CMD_READ, 16'h0000, 8'h00, 12'h000);
        select_and_write(8'd7, 8'h00);
        select_and_write(8'd1, 8'hff);
        select_and_write(8'd8, 8'hff);
        queue_item(CMD_READ, ADDR_SEL, 8'h00, 12'h000);
        select_and_write(8'd9, 8'h1f);
        select_and_write(8'd11, 8'h01);
        select_and_write(8'd13, 8'h0e);
        queue_item(CMD_RENDER, 16'hffff, 8'hff, 12'h000);
        queue_item(CMD_RENDER, 16'h0000, 8'h00, 12'hfff);
        // A port with bit 1 set and an undecoded port both ignore the write.
        queue_item(CMD_WRITE, ADDR_OFF, 8'h00, 12'h000);
        queue_item(CMD_WRITE, 16'h4000, 8'h00, 12'h000);
        queue_item(CMD_READ, ADDR_SEL, 8'h00, 12'h000);
        queue_item(CMD_NONE, 16'hffff, 8'hff, 12'hfff);
        queue_item(CMD_RENDER, 16'h0000, 8'h00, 12'd300);
      end else if (phase == 1) begin
        // Selection beyond fifteen: write ignored, read misses.
        select_and_write(8'hc8, 8'h55);
        queue_item(CMD_READ, ADDR_SEL, 8'h00, 12'h000);
        select_and_write(8'd13, 8'h08);
        queue_item(CMD_RENDER, 16'h0000, 8'h00, 12'd200);
      end
      queue_random(45);
      wait_until_idle();
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
sv/psg_pkg.sv
sv/psg_gen.sv
sv/psg_mac.sv
sv/psg_three_voice_sound_generator.sv
tb/tb_top.sv
